// ----- rtl/core/mrs_pkg.sv -----
// Package with the constants, payload types and CRC control type of the Modbus RTU slave.
package mrs_pkg;

    localparam int GAP_TICKS = 5;
    localparam int RX_LIMIT  = 20;
    localparam int REG_COUNT = 6;
    localparam int FRAME_LEN = 8;
    localparam int BODY_LEN  = 6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  ADDR_BCAST = 8'hFF;
    localparam logic [7:0]  FC_READ    = 8'h03;
    localparam logic [7:0]  FC_WRITE   = 8'h06;
    localparam logic [7:0]  READ_BYTES = 8'h06;
    localparam logic [15:0] REG_PPM_A  = 16'h0000;
    localparam logic [15:0] REG_PPM_B  = 16'h0001;
    localparam logic [15:0] READ_COUNT = 16'h0001;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam logic KIND_TX  = 1'b0;
    localparam logic KIND_REG = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  rx_byte;
        logic [12:0] co2_ppm;
        logic        co2_valid;
    } t_in_item;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
    } t_out_item;

    typedef struct packed {
        logic init;
        logic load;
        logic shift;
    } t_crc_ctrl;

endpackage

// ----- rtl/core/mrs_in_if.sv -----
// Handshake interface carrying received bytes and ticks into the slave.
interface mrs_in_if;
    logic             valid;
    logic             ready;
    mrs_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/mrs_out_if.sv -----
// Handshake interface carrying reply bytes and register writes out of the slave.
interface mrs_out_if;
    logic              valid;
    logic              ready;
    mrs_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/mrs_crc_unit.sv -----
// Bit-serial CRC-16/Modbus unit shared by frame checking and reply generation.
module mrs_crc_unit (
    input  logic                i_clk,
    input  mrs_pkg::t_crc_ctrl  i_ctrl,
    input  logic [7:0]          i_byte,
    output logic [15:0]         o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.init) begin
            n_crc = mrs_pkg::CRC_INIT;
        end else if (i_ctrl.load) begin
            n_crc = r_crc ^ {8'h00, i_byte};
        end else if (i_ctrl.shift) begin
            if (r_crc[0]) begin
                n_crc = (r_crc >> 1) ^ mrs_pkg::CRC_POLY;
            end else begin
                n_crc = r_crc >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule

// ----- rtl/core/modbus_rtu_slave_frame_engine_top.sv -----
// Top level of the Modbus RTU slave frame engine: receive buffer, sequencer and result register.
// A received byte, a tick that does not close a frame, or a tick that closes a frame that is not
// eight bytes long or that overflowed is taken without leaving the idle state. The tick that closes
// an eight-byte frame starts the sequencer, which runs the six body bytes through the bit-serial
// CRC unit, loading each byte and then shifting it bit by bit, and then decides, where a register
// write waits for the output register. A read request then runs six reply bytes through the same
// unit and sends eight bytes at one a cycle as the sink takes them. Input ready is low until the
// sequencer is back in idle. Results leave through an output register, so a finished result can
// wait for the sink while new bytes are taken.
module modbus_rtu_slave_frame_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    mrs_in_if.sink      i_in,
    mrs_out_if.source   o_out
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SEND   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_byte_count, n_byte_count;
    logic [2:0]  r_gap, n_gap;
    logic        r_overflow, n_overflow;
    logic [7:0]  r_slave_addr;
    logic [7:0]  r_frame [mrs_pkg::FRAME_LEN];
    logic        r_reply, n_reply;
    logic [2:0]  r_idx, n_idx;
    logic [2:0]  r_bit, n_bit;
    logic [12:0] r_ppm, n_ppm;
    logic        r_valid, n_valid;
    logic        r_out_valid, n_out_valid;
    mrs_pkg::t_out_item r_out, n_out;

    mrs_pkg::t_crc_ctrl crc_ctrl;
    logic [7:0]  crc_byte;
    logic [15:0] crc_value;
    logic [7:0]  reply_byte;
    logic        in_accept;
    logic        out_free;
    logic        frame_store_we;
    logic [15:0] req_reg;
    logic [15:0] req_val;
    logic        frame_ok;
    logic        read_ok;
    logic        write_ok;

    mrs_crc_unit u_crc (
        .i_clk  (i_clk),
        .i_ctrl (crc_ctrl),
        .i_byte (crc_byte),
        .o_crc  (crc_value)
    );

    assign i_in.ready    = (r_state == S_IDLE);
    assign in_accept     = i_in.valid && i_in.ready;
    assign out_free      = !r_out_valid || o_out.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign req_reg = {r_frame[2], r_frame[3]};
    assign req_val = {r_frame[4], r_frame[5]};
    assign frame_ok = (crc_value == {r_frame[7], r_frame[6]})
                   && ((r_frame[0] == r_slave_addr) || (r_frame[0] == mrs_pkg::ADDR_BCAST));
    assign read_ok  = (r_frame[1] == mrs_pkg::FC_READ) && (r_frame[0] != mrs_pkg::ADDR_BCAST)
                   && ((req_reg == mrs_pkg::REG_PPM_A) || (req_reg == mrs_pkg::REG_PPM_B))
                   && (req_val == mrs_pkg::READ_COUNT) && r_valid;
    assign write_ok = (r_frame[1] == mrs_pkg::FC_WRITE)
                   && (req_reg < 16'(mrs_pkg::REG_COUNT));

    always_comb begin
        case (r_idx)
            3'd0:    reply_byte = r_frame[0];
            3'd1:    reply_byte = mrs_pkg::FC_READ;
            3'd2:    reply_byte = mrs_pkg::FC_READ;
            3'd3:    reply_byte = mrs_pkg::READ_BYTES;
            3'd4:    reply_byte = {3'b000, r_ppm[12:8]};
            3'd5:    reply_byte = r_ppm[7:0];
            3'd6:    reply_byte = crc_value[7:0];
            3'd7:    reply_byte = crc_value[15:8];
            default: reply_byte = 8'h00;
        endcase
    end

    assign crc_byte = r_reply ? reply_byte : r_frame[r_idx];

    always_comb begin
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_gap        = r_gap;
        n_overflow   = r_overflow;
        n_reply      = r_reply;
        n_idx        = r_idx;
        n_bit        = r_bit;
        n_ppm        = r_ppm;
        n_valid      = r_valid;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;
        crc_ctrl     = '0;
        frame_store_we = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept && i_in.payload.op == mrs_pkg::OP_BYTE) begin
                    n_gap = 3'd0;
                    if (r_byte_count < 5'(mrs_pkg::RX_LIMIT)) begin
                        frame_store_we = (r_byte_count < 5'(mrs_pkg::FRAME_LEN));
                        n_byte_count   = r_byte_count + 5'd1;
                    end else begin
                        n_overflow = 1'b1;
                    end
                end else if (in_accept && r_byte_count != 5'd0) begin
                    if (r_gap < 3'(mrs_pkg::GAP_TICKS)) begin
                        n_gap = r_gap + 3'd1;
                    end
                    if (n_gap == 3'(mrs_pkg::GAP_TICKS)) begin
                        n_byte_count = 5'd0;
                        n_gap        = 3'd0;
                        n_overflow   = 1'b0;
                        n_ppm        = i_in.payload.co2_ppm;
                        n_valid      = i_in.payload.co2_valid;
                        if (!r_overflow && r_byte_count == 5'(mrs_pkg::FRAME_LEN)) begin
                            crc_ctrl.init = 1'b1;
                            n_reply = 1'b0;
                            n_idx   = 3'd0;
                            n_state = S_LOAD;
                        end
                    end
                end
            end
            S_LOAD: begin
                crc_ctrl.load = 1'b1;
                n_bit   = 3'd0;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                crc_ctrl.shift = 1'b1;
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    if (r_idx == 3'(mrs_pkg::BODY_LEN - 1)) begin
                        n_idx   = 3'd0;
                        n_state = r_reply ? S_SEND : S_DECIDE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = S_LOAD;
                    end
                end
            end
            S_DECIDE: begin
                if (!frame_ok) begin
                    n_state = S_IDLE;
                end else if (read_ok) begin
                    crc_ctrl.init = 1'b1;
                    n_reply = 1'b1;
                    n_idx   = 3'd0;
                    n_state = S_LOAD;
                end else if (write_ok) begin
                    if (out_free) begin
                        n_out_valid     = 1'b1;
                        n_out.out_kind  = mrs_pkg::KIND_REG;
                        n_out.tx_byte   = 8'h00;
                        n_out.tx_last   = 1'b0;
                        n_out.reg_index = req_reg[2:0];
                        n_out.reg_value = req_val;
                        n_state         = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEND: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.out_kind  = mrs_pkg::KIND_TX;
                    n_out.tx_byte   = reply_byte;
                    n_out.tx_last   = (r_idx == 3'(mrs_pkg::FRAME_LEN - 1));
                    n_out.reg_index = 3'd0;
                    n_out.reg_value = 16'h0000;
                    n_idx           = r_idx + 3'd1;
                    if (r_idx == 3'(mrs_pkg::FRAME_LEN - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_byte_count <= 5'd0;
            r_gap        <= 3'd0;
            r_overflow   <= 1'b0;
            r_slave_addr <= 8'd1;
            r_out_valid  <= 1'b0;
            r_reply      <= 1'b0;
            r_idx        <= 3'd0;
            r_bit        <= 3'd0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_gap        <= n_gap;
            r_overflow   <= n_overflow;
            r_out_valid  <= n_out_valid;
            r_reply      <= n_reply;
            r_idx        <= n_idx;
            r_bit        <= n_bit;
            if (i_cfg_wr_en) begin
                r_slave_addr <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ppm   <= n_ppm;
        r_valid <= n_valid;
        r_out   <= n_out;
        if (frame_store_we) begin
            r_frame[r_byte_count[2:0]] <= i_in.payload.rx_byte;
        end
    end

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= 5'(mrs_pkg::RX_LIMIT))
        else $error("receive count beyond limit");

    a_busy_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_byte_count == 5'd0 && !r_overflow))
        else $error("receive state not cleared while a frame is processed");

    a_reg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.out_kind == mrs_pkg::KIND_REG)
            |-> (r_out.reg_index < 3'(mrs_pkg::REG_COUNT)))
        else $error("register write outside the holding register range");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tx_last) |-> (r_out.out_kind == mrs_pkg::KIND_TX))
        else $error("last flag on a register write");

    a_send_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND && out_free && r_idx == 3'(mrs_pkg::FRAME_LEN - 1))
            |=> (r_state == S_IDLE && r_out.tx_last))
        else $error("reply did not end on its last byte");

endmodule

// ----- test/mrs_frame_checker.sv -----
// Checker that predicts Modbus RTU slave results from observed transactions and compares them.
`timescale 1ns / 100ps

module mrs_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    mrs_in_if          i_in_mon,
    mrs_out_if         i_out_mon,
    output int         o_fail_count,
    output int         o_pending
);

    typedef logic [7:0] t_body[mrs_pkg::BODY_LEN];

    logic [7:0]         own_addr;
    logic [7:0]         frame_bytes[mrs_pkg::FRAME_LEN];
    logic [4:0]         rx_count;
    logic [2:0]         silence;
    logic               rx_overrun;
    mrs_pkg::t_out_item expected_q[$];
    int                 fails = 0;

    function automatic logic [15:0] body_crc(input t_body b);
        logic [15:0] c;
        c = mrs_pkg::CRC_INIT;
        foreach (b[i]) begin
            c = c ^ {8'h00, b[i]};
            repeat (8) c = c[0] ? ((c >> 1) ^ mrs_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    always @(posedge i_clk) begin : monitor
        mrs_pkg::t_out_item got;
        mrs_pkg::t_out_item want;
        mrs_pkg::t_in_item  item;
        t_body              body;
        t_body              reply;
        logic [15:0]        crc;
        logic [15:0]        reg_no;
        logic [15:0]        word;
        if (!i_rst_n) begin
            own_addr   = 8'h01;
            rx_count   = '0;
            silence    = '0;
            rx_overrun = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                own_addr = i_cfg_wr_data;
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.payload;
                if (expected_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result kind=%0b tx=%02h last=%0b idx=%0d val=%04h",
                             $time, got.out_kind, got.tx_byte, got.tx_last, got.reg_index,
                             got.reg_value);
                end else begin
                    want = expected_q.pop_front();
                    if (got.out_kind !== want.out_kind || got.tx_byte !== want.tx_byte ||
                        got.tx_last !== want.tx_last || got.reg_index !== want.reg_index ||
                        got.reg_value !== want.reg_value) begin
                        fails++;
                        $display("%0t: mismatch expected kind=%0b tx=%02h last=%0b idx=%0d val=%04h",
                                 $time, want.out_kind, want.tx_byte, want.tx_last,
                                 want.reg_index, want.reg_value);
                        $display("%0t:          actual kind=%0b tx=%02h last=%0b idx=%0d val=%04h",
                                 $time, got.out_kind, got.tx_byte, got.tx_last,
                                 got.reg_index, got.reg_value);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                item = i_in_mon.payload;
                if (item.op == mrs_pkg::OP_BYTE) begin
                    if (rx_count < mrs_pkg::RX_LIMIT) begin
                        if (rx_count < mrs_pkg::FRAME_LEN) begin
                            frame_bytes[rx_count] = item.rx_byte;
                        end
                        rx_count = rx_count + 5'd1;
                    end else begin
                        rx_overrun = 1'b1;
                    end
                    silence = '0;
                end else if (rx_count != 0) begin
                    if (silence < mrs_pkg::GAP_TICKS) begin
                        silence = silence + 3'd1;
                    end
                    if (silence == mrs_pkg::GAP_TICKS) begin
                        foreach (body[i]) body[i] = frame_bytes[i];
                        reg_no = {body[2], body[3]};
                        word   = {body[4], body[5]};
                        if (!rx_overrun && rx_count == mrs_pkg::FRAME_LEN &&
                            body_crc(body) == {frame_bytes[7], frame_bytes[6]} &&
                            (body[0] == own_addr || body[0] == mrs_pkg::ADDR_BCAST)) begin
                            if (body[1] == mrs_pkg::FC_READ &&
                                body[0] != mrs_pkg::ADDR_BCAST &&
                                (reg_no == mrs_pkg::REG_PPM_A ||
                                 reg_no == mrs_pkg::REG_PPM_B) &&
                                word == mrs_pkg::READ_COUNT && item.co2_valid) begin
                                reply = '{body[0], mrs_pkg::FC_READ, mrs_pkg::FC_READ,
                                          mrs_pkg::READ_BYTES, {3'b000, item.co2_ppm[12:8]},
                                          item.co2_ppm[7:0]};
                                crc = body_crc(reply);
                                foreach (reply[i]) begin
                                    expected_q.push_back(mrs_pkg::t_out_item'{
                                        mrs_pkg::KIND_TX, reply[i], 1'b0, 3'd0, 16'd0});
                                end
                                expected_q.push_back(mrs_pkg::t_out_item'{
                                    mrs_pkg::KIND_TX, crc[7:0], 1'b0, 3'd0, 16'd0});
                                expected_q.push_back(mrs_pkg::t_out_item'{
                                    mrs_pkg::KIND_TX, crc[15:8], 1'b1, 3'd0, 16'd0});
                            end else if (body[1] == mrs_pkg::FC_WRITE &&
                                         reg_no < mrs_pkg::REG_COUNT) begin
                                expected_q.push_back(mrs_pkg::t_out_item'{
                                    mrs_pkg::KIND_REG, 8'h00, 1'b0, reg_no[2:0], word});
                            end
                        end
                        rx_count   = '0;
                        silence    = '0;
                        rx_overrun = 1'b0;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

// ----- test/tb_modbus_rtu_slave_frame_engine_top.sv -----
// Testbench top for the Modbus RTU slave frame engine: stimulus, address writes and verdict.
`timescale 1ns / 100ps

module tb_modbus_rtu_slave_frame_engine_top;

    typedef logic [7:0] t_bytes[$];

    localparam int SETTLE_CYCLES = 160;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic [7:0] own_addr;
    bit         idle_on = 1'b1;
    int         items_sent = 0;
    int         fail_count;
    int         pending;

    mrs_in_if  in_bus ();
    mrs_out_if out_bus ();

    modbus_rtu_slave_frame_engine_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (in_bus),
        .o_out        (out_bus)
    );

    mrs_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_mon     (in_bus),
        .i_out_mon    (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk) begin
        out_bus.ready <= !idle_on || ($urandom_range(99) >= 17);
    end

    function automatic t_bytes request(input logic [7:0] addr, input logic [7:0] fc,
                                       input logic [15:0] reg_no, input logic [15:0] word);
        t_bytes      b;
        logic [15:0] c;
        b = '{addr, fc, reg_no[15:8], reg_no[7:0], word[15:8], word[7:0]};
        c = mrs_pkg::CRC_INIT;
        foreach (b[i]) begin
            c = c ^ {8'h00, b[i]};
            repeat (8) c = c[0] ? ((c >> 1) ^ mrs_pkg::CRC_POLY) : (c >> 1);
        end
        b.push_back(c[7:0]);
        b.push_back(c[15:8]);
        return b;
    endfunction

    task automatic put_item(input logic op, input logic [7:0] data, input logic [12:0] ppm,
                            input logic ok);
        mrs_pkg::t_in_item it;
        it = '{op: op, rx_byte: data, co2_ppm: ppm, co2_valid: ok};
        if (idle_on && $urandom_range(99) < 17) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.payload <= it;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame(input t_bytes bytes, input logic [12:0] ppm, input logic ok);
        foreach (bytes[i]) begin
            if (i != 0 && $urandom_range(99) < 8) begin
                repeat ($urandom_range(mrs_pkg::GAP_TICKS - 1, 1)) begin
                    put_item(mrs_pkg::OP_TICK, 8'($urandom), 13'($urandom), 1'($urandom));
                end
            end
            put_item(mrs_pkg::OP_BYTE, bytes[i], 13'($urandom), 1'($urandom));
        end
        repeat (mrs_pkg::GAP_TICKS - 1) begin
            put_item(mrs_pkg::OP_TICK, 8'($urandom), 13'($urandom), 1'($urandom));
        end
        put_item(mrs_pkg::OP_TICK, 8'($urandom), ppm, ok);
        if ($urandom_range(99) < 20) begin
            put_item(mrs_pkg::OP_TICK, 8'($urandom), 13'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_frame();
        t_bytes      b;
        int          pick;
        int          extra;
        logic [12:0] ppm;
        pick = $urandom_range(99);
        if (pick < 30) begin
            b = request(own_addr, mrs_pkg::FC_READ, 16'($urandom_range(1)),
                        mrs_pkg::READ_COUNT);
        end else if (pick < 50) begin
            b = request(own_addr, mrs_pkg::FC_WRITE,
                        ($urandom_range(99) < 80) ? 16'($urandom_range(mrs_pkg::REG_COUNT - 1))
                                                  : 16'($urandom),
                        16'($urandom));
        end else if (pick < 55) begin
            b = request(mrs_pkg::ADDR_BCAST, mrs_pkg::FC_WRITE, 16'($urandom_range(7)),
                        16'($urandom));
        end else if (pick < 60) begin
            b = request(mrs_pkg::ADDR_BCAST, mrs_pkg::FC_READ, 16'($urandom_range(1)),
                        mrs_pkg::READ_COUNT);
        end else if (pick < 65) begin
            b = request(own_addr, mrs_pkg::FC_READ, 16'($urandom_range(3)),
                        16'($urandom_range(2)));
        end else if (pick < 70) begin
            b = request(own_addr, 8'($urandom), 16'($urandom_range(7)), 16'($urandom));
        end else if (pick < 75) begin
            b = request(own_addr,
                        ($urandom_range(1) != 0) ? mrs_pkg::FC_READ : mrs_pkg::FC_WRITE,
                        16'($urandom_range(1)), mrs_pkg::READ_COUNT);
            extra = $urandom_range(7);
            b[extra] = b[extra] ^ (8'h01 << $urandom_range(7));
        end else if (pick < 80) begin
            b = request(8'($urandom), mrs_pkg::FC_WRITE, 16'($urandom_range(5)),
                        16'($urandom));
        end else if (pick < 85) begin
            b = request(own_addr, mrs_pkg::FC_WRITE, 16'($urandom_range(5)), 16'($urandom));
            repeat ($urandom_range(7, 1)) void'(b.pop_back());
        end else if (pick < 95) begin
            b = request(own_addr, mrs_pkg::FC_READ, mrs_pkg::REG_PPM_A, mrs_pkg::READ_COUNT);
            extra = (pick < 90) ? $urandom_range(12, 1) : $urandom_range(18, 13);
            repeat (extra) b.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(10, 1)) b.push_back(8'($urandom));
        end
        pick = $urandom_range(99);
        ppm  = (pick < 10) ? 13'd0 : (pick < 20) ? 13'h1FFF : 13'($urandom);
        send_frame(b, ppm, $urandom_range(99) < 85);
    endtask

    task automatic write_addr(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        own_addr = value;
    endtask

    task automatic settle();
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        t_bytes none;
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= 8'h00;
        in_bus.valid   <= 1'b0;
        in_bus.payload <= '0;
        own_addr = 8'h01;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases run at the address that reset leaves.
        send_frame(none, 13'd0, 1'b1);
        send_frame(request(own_addr, mrs_pkg::FC_READ, mrs_pkg::REG_PPM_A,
                           mrs_pkg::READ_COUNT), 13'd0, 1'b1);
        send_frame(request(own_addr, mrs_pkg::FC_READ, mrs_pkg::REG_PPM_B,
                           mrs_pkg::READ_COUNT), 13'h1FFF, 1'b1);
        send_frame(request(own_addr, mrs_pkg::FC_WRITE, 16'd5, 16'hFFFF), 13'd100, 1'b1);
        settle();

        write_addr(8'h00);
        while (items_sent < 75) random_frame();
        settle();
        idle_on <= 1'b0;
        write_addr(8'hFF);
        while (items_sent < 100) random_frame();
        settle();
        idle_on <= 1'b1;
        write_addr(8'($urandom));
        while (items_sent < 125) random_frame();
        settle();
        write_addr(8'h01);
        while (items_sent < 150) random_frame();
        settle();

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/mrs_pkg.sv
rtl/core/mrs_in_if.sv
rtl/core/mrs_out_if.sv
rtl/core/mrs_crc_unit.sv
rtl/core/modbus_rtu_slave_frame_engine_top.sv
test/mrs_frame_checker.sv
test/tb_modbus_rtu_slave_frame_engine_top.sv
